/* sv/mbps_pkg.sv */
package mbps_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_PATTERN_DEF = 16;
   localparam int ADDR_WIDTH_DEF  = 32;

   // Fixed field widths.
   localparam int PAT_BYTES  = 16;
   localparam int LEN_W      = 5;
   localparam int START_W    = 32;
   localparam int POS_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START_OFFSET   = 3'd4;

   // Search setup as seen by the scan stage.
   typedef struct packed {
      logic [PAT_BYTES-1:0][7:0] pattern;
      logic [PAT_BYTES-1:0]      care;
      logic [LEN_W-1:0]          length;
      logic [START_W-1:0]        start;
   } cfg_type;

   // Result handed from the scan stage to the output register.
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [POS_W-1:0] position;
   } scan_result_type;

endpackage

/* sv/mbps_csr.sv */
module mbps_csr #(
   parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0] csr_data,
   output mbps_pkg::cfg_type               cfg
);
   import mbps_pkg::*;

   localparam int PAT_CAP = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(PAT_CAP);

   logic [63:0]          pattern_low_ff;
   logic [63:0]          pattern_high_ff;
   logic [PAT_BYTES-1:0] care_ff;
   logic [LEN_W-1:0]     length_ff;
   logic [START_W-1:0]   start_ff;
   logic                 write;

   // Writes are to be issued only while idle; the block does not enforce it, and the port is always ready.
   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;

   // Register file; indexes past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_ff         <= '1;
         length_ff       <= LEN_W'(1);
         start_ff        <= '0;
      end else if (write) begin
         unique case (csr_index)
            REG_PATTERN_LOW:    pattern_low_ff  <= csr_data[63:0];
            REG_PATTERN_HIGH:   pattern_high_ff <= csr_data[63:0];
            REG_CARE_MASK:      care_ff         <= csr_data[PAT_BYTES-1:0];
            REG_PATTERN_LENGTH: length_ff       <= csr_data[LEN_W-1:0];
            REG_START_OFFSET:   start_ff        <= csr_data[START_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A length of zero counts as one, and long patterns are cut to the window.
   always_comb begin
      cfg.pattern = {pattern_high_ff, pattern_low_ff};
      cfg.care    = care_ff;
      cfg.start   = start_ff;
      if (length_ff == '0) begin
         cfg.length = LEN_W'(1);
      end else if (length_ff > LEN_CAP) begin
         cfg.length = LEN_CAP;
      end else begin
         cfg.length = length_ff;
      end
   end

endmodule

/* sv/mbps_scan.sv */
module mbps_scan #(
   parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
   parameter int ADDR_WIDTH  = mbps_pkg::ADDR_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mbps_pkg::cfg_type         cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_last_byte,
   input  logic                      out_free,
   output mbps_pkg::scan_result_type result
);
   import mbps_pkg::*;

   localparam int PAT_CAP = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
   localparam int CMP_W   = (ADDR_WIDTH > START_W) ? ADDR_WIDTH : START_W;

   // Input register.
   logic                        in_valid_ff, in_valid_in;
   logic [7:0]                  in_byte_ff;
   logic                        in_last_ff;

   // Per-buffer state.
   logic [PAT_CAP-1:0][7:0]     window_ff, window_in;
   logic [ADDR_WIDTH-1:0]       count_ff, count_in;
   logic                        seen_ff, seen_in;

   logic                        accept;
   logic                        fire;
   logic [PAT_CAP-1:0][7:0]     window_new;
   logic                        not_sat;
   logic [ADDR_WIDTH:0]         count_next;
   logic [ADDR_WIDTH:0]         start_pos;
   logic                        enough;
   logic [CMP_W-1:0]            start_ext;
   logic                        eligible;
   logic                        bytes_ok;
   logic                        hit;

   assign fire      = in_valid_ff & out_free;
   assign req_ready = ~in_valid_ff | out_free;
   assign accept    = req_valid & req_ready;

   // Input register load and drain.
   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // Window with the held byte shifted in at the newest end.
   always_comb begin
      window_new[0] = in_byte_ff;
      for (int j = 1; j < PAT_CAP; j++) begin
         window_new[j] = window_ff[j-1];
      end
   end

   // Start position of a match that ends on this byte, and its eligibility.
   assign not_sat    = (count_ff != '1);
   assign count_next = {1'b0, count_ff} + (ADDR_WIDTH+1)'(1);
   assign start_pos  = count_next - (ADDR_WIDTH+1)'(cfg.length);
   assign enough     = (count_next >= (ADDR_WIDTH+1)'(cfg.length));
   assign start_ext  = CMP_W'(cfg.start);
   assign eligible   = ~seen_ff & not_sat & enough &
                       (CMP_W'(start_pos[ADDR_WIDTH-1:0]) >= start_ext);

   // Masked compare: pattern byte i sits at window slot length-1-i.
   always_comb begin
      logic [7:0] sel;
      bytes_ok = 1'b1;
      for (int i = 0; i < PAT_CAP; i++) begin
         sel = '0;
         for (int j = 0; j < PAT_CAP; j++) begin
            if ((6'(i) + 6'(j) + 6'd1) == {1'b0, cfg.length}) begin
               sel = window_new[j];
            end
         end
         if ((6'(i) < {1'b0, cfg.length}) && cfg.care[i] && (sel != cfg.pattern[i])) begin
            bytes_ok = 1'b0;
         end
      end
   end

   assign hit = eligible & bytes_ok;

   // Result: a match, or a miss report at the end of a buffer.
   always_comb begin
      logic [CMP_W-1:0] pos_ext;
      pos_ext         = CMP_W'(start_pos[ADDR_WIDTH-1:0]);
      result.valid    = fire & (hit | (in_last_ff & ~seen_ff));
      result.found    = hit;
      result.position = hit ? pos_ext[POS_W-1:0] : '0;
   end

   // State update for a transfer leaving the input register.
   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      if (fire) begin
         if (in_last_ff) begin
            window_in = '0;
            count_in  = '0;
            seen_in   = 1'b0;
         end else begin
            window_in = window_new;
            count_in  = not_sat ? count_next[ADDR_WIDTH-1:0] : count_ff;
            seen_in   = seen_ff | hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seen_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

/* sv/masked_byte_pattern_search_unit.sv */
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_data_byte, req_last_byte
// rsp      out        rsp_valid/rsp_ready    rsp_found, rsp_match_position
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One byte is taken per cycle unless a waiting result stalls req; a result
// passes through the input register and then the result register.
// The masked compare and the start-position check between them set the path.
// Reset is synchronous and clears the buffer position, the match flag and the valid flags.
// A result waiting on rsp_ready holds the input register, which then stalls req.
module masked_byte_pattern_search_unit #(
   parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
   parameter int ADDR_WIDTH  = mbps_pkg::ADDR_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic [mbps_pkg::POS_W-1:0]      rsp_match_position,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0] csr_data
);
   import mbps_pkg::*;

   cfg_type          cfg;
   scan_result_type  result;
   logic             out_free;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff;
   logic [POS_W-1:0] rsp_pos_ff;

   mbps_csr #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cfg      (cfg)
   );

   mbps_scan #(
      .MAX_PATTERN(MAX_PATTERN),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .out_free     (out_free),
      .result       (result)
   );

   // The result register is free when empty or when its transfer completes.
   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_found_ff <= result.found;
         rsp_pos_ff   <= result.position;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_match_position = rsp_pos_ff;

endmodule
